FILE: hdl/wfp_pkg.sv
package wfp_pkg;

  localparam int unsigned WFP_QUEUE_DEPTH = 2;

  localparam logic RK_HEADER = 1'b0;
  localparam logic RK_TEXT   = 1'b1;

  localparam logic [2:0] FK_CONT     = 3'd0;
  localparam logic [2:0] FK_TEXT     = 3'd1;
  localparam logic [2:0] FK_BINARY   = 3'd2;
  localparam logic [2:0] FK_CLOSE    = 3'd3;
  localparam logic [2:0] FK_PING     = 3'd4;
  localparam logic [2:0] FK_PONG     = 3'd5;
  localparam logic [2:0] FK_RESERVED = 3'd6;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT16,
    PH_EXT64,
    PH_KEY,
    PH_PAY
  } wfp_phase_t;

  typedef struct packed {
    logic        result_kind;
    logic        fin;
    logic [2:0]  frame_kind;
    logic        masked;
    logic [63:0] length;
    logic [7:0]  data;
    logic [7:0]  key;
    logic        last;
  } wfp_res_t;

  function automatic logic [2:0] kind_of_opcode(input logic [3:0] op);
    logic [2:0] k;
    unique case (op)
      OP_CONT:   k = FK_CONT;
      OP_TEXT:   k = FK_TEXT;
      OP_BINARY: k = FK_BINARY;
      OP_CLOSE:  k = FK_CLOSE;
      OP_PING:   k = FK_PING;
      OP_PONG:   k = FK_PONG;
      default:   k = FK_RESERVED;
    endcase
    return k;
  endfunction

endpackage

FILE: hdl/websocket_frame_parser_top.sv
// A result is written into the queue and then into the output register before it appears.
// Throughput: one input beat per cycle unless the queue is full; the parser and output
// stage are decoupled by a queue (two entries by default): either may stall until full.
// Reset: synchronous, active low; the parser waits for header byte 0 and the queue
// and output register are emptied.
module websocket_frame_parser_top #(
  parameter int unsigned QUEUE_DEPTH = wfp_pkg::WFP_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic        out_fin_flag,
  output logic [2:0]  out_frame_kind,
  output logic        out_is_masked,
  output logic [63:0] out_payload_length,
  output logic [7:0]  out_text_byte,
  output logic        out_last_of_payload
);
  import wfp_pkg::*;

  logic     q_full;
  logic     q_push;
  wfp_res_t q_push_data;
  logic     q_pop;
  logic     q_valid;
  wfp_res_t q_data;

  wfp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_frame_byte  (in_frame_byte),
    .in_frame_start (in_frame_start),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_push_data)
  );

  wfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  wfp_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_data              (q_data),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_fin_flag        (out_fin_flag),
    .out_frame_kind      (out_frame_kind),
    .out_is_masked       (out_is_masked),
    .out_payload_length  (out_payload_length),
    .out_text_byte       (out_text_byte),
    .out_last_of_payload (out_last_of_payload)
  );

endmodule

FILE: hdl/wfp_front.sv
module wfp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_frame_byte,
  input  logic              in_frame_start,
  input  logic              q_full,
  output logic              q_push,
  output wfp_pkg::wfp_res_t q_data
);
  import wfp_pkg::*;

  wfp_phase_t  phase_r, phase_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        fin_r, fin_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic        masked_r, masked_nxt;
  logic [63:0] len_r, len_nxt;
  logic [7:0]  key_r [4];
  logic [7:0]  key_nxt [4];
  logic [63:0] remain_r, remain_nxt;
  logic [1:0]  pidx_r, pidx_nxt;

  logic        fire;
  logic        finish;
  logic        ext_done;
  wfp_phase_t  ph;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      idx_r    <= '0;
      fin_r    <= 1'b0;
      kind_r   <= FK_RESERVED;
      masked_r <= 1'b1;
      len_r    <= '0;
      remain_r <= '0;
      pidx_r   <= '0;
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
    end else begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      fin_r    <= fin_nxt;
      kind_r   <= kind_nxt;
      masked_r <= masked_nxt;
      len_r    <= len_nxt;
      remain_r <= remain_nxt;
      pidx_r   <= pidx_nxt;
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= key_nxt[i];
      end
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    fin_nxt    = fin_r;
    kind_nxt   = kind_r;
    masked_nxt = masked_r;
    len_nxt    = len_r;
    remain_nxt = remain_r;
    pidx_nxt   = pidx_r;
    for (int i = 0; i < 4; i++) begin
      key_nxt[i] = key_r[i];
    end
    finish   = 1'b0;
    ext_done = 1'b0;
    q_push   = 1'b0;
    q_data   = '0;
    ph       = in_frame_start ? PH_HDR0 : phase_r;

    if (fire) begin
      unique case (ph)
        PH_HDR0: begin
          fin_nxt   = in_frame_byte[7];
          kind_nxt  = kind_of_opcode(in_frame_byte[3:0]);
          idx_nxt   = '0;
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          masked_nxt = in_frame_byte[7];
          idx_nxt    = '0;
          len_nxt    = '0;
          if (in_frame_byte[6:0] == LEN_EXT16) begin
            phase_nxt = PH_EXT16;
          end else if (in_frame_byte[6:0] == LEN_EXT64) begin
            phase_nxt = PH_EXT64;
          end else begin
            len_nxt = {57'd0, in_frame_byte[6:0]};
            if (in_frame_byte[7]) begin
              phase_nxt = PH_KEY;
            end else begin
              finish = 1'b1;
            end
          end
        end
        PH_EXT16, PH_EXT64: begin
          len_nxt  = {len_r[55:0], in_frame_byte};
          idx_nxt  = idx_r + 3'd1;
          ext_done = (ph == PH_EXT16) ? (idx_nxt == 3'd2) : (idx_nxt == 3'd0);
          if (ext_done) begin
            idx_nxt = '0;
            if (masked_r) begin
              phase_nxt = PH_KEY;
            end else begin
              finish = 1'b1;
            end
          end
        end
        PH_KEY: begin
          key_nxt[idx_r[1:0]] = in_frame_byte;
          idx_nxt             = idx_r + 3'd1;
          if (idx_nxt[2]) begin
            idx_nxt = '0;
            finish  = 1'b1;
          end
        end
        PH_PAY: begin
          remain_nxt = remain_r - 64'd1;
          pidx_nxt   = pidx_r + 2'd1;
          if (remain_r == 64'd1) begin
            phase_nxt = PH_HDR0;
          end
          if (kind_r == FK_TEXT) begin
            q_push             = 1'b1;
            q_data.result_kind = RK_TEXT;
            q_data.fin         = fin_r;
            q_data.frame_kind  = kind_r;
            q_data.masked      = masked_r;
            q_data.length      = len_r;
            q_data.data        = in_frame_byte;
            q_data.key         = masked_r ? key_r[pidx_r] : 8'd0;
            q_data.last        = (remain_r == 64'd1);
          end
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase

      if (finish) begin
        q_push             = 1'b1;
        q_data.result_kind = RK_HEADER;
        q_data.fin         = fin_nxt;
        q_data.frame_kind  = kind_nxt;
        q_data.masked      = masked_nxt;
        q_data.length      = len_nxt;
        q_data.data        = 8'd0;
        q_data.key         = 8'd0;
        q_data.last        = (kind_nxt == FK_TEXT) && (len_nxt == 64'd0);
        remain_nxt         = len_nxt;
        pidx_nxt           = '0;
        phase_nxt          = (len_nxt == 64'd0) ? PH_HDR0 : PH_PAY;
      end
    end
  end

endmodule

FILE: hdl/wfp_queue.sv
module wfp_queue #(
  parameter int unsigned DEPTH = wfp_pkg::WFP_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wfp_pkg::wfp_res_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output wfp_pkg::wfp_res_t q_data
);
  import wfp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  wfp_res_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign q_valid = (cnt_r != '0);
  assign q_data  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hdl/wfp_back.sv
module wfp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  wfp_pkg::wfp_res_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_result_kind,
  output logic              out_fin_flag,
  output logic [2:0]        out_frame_kind,
  output logic              out_is_masked,
  output logic [63:0]       out_payload_length,
  output logic [7:0]        out_text_byte,
  output logic              out_last_of_payload
);
  import wfp_pkg::*;

  logic        valid_r, valid_nxt;
  logic        kind_r;
  logic        fin_r;
  logic [2:0]  fkind_r;
  logic        masked_r;
  logic [63:0] len_r;
  logic [7:0]  text_r;
  logic        last_r;
  logic        take;

  assign take  = q_valid && (!valid_r || out_ready);
  assign q_pop = take;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r   <= q_data.result_kind;
      fin_r    <= q_data.fin;
      fkind_r  <= q_data.frame_kind;
      masked_r <= q_data.masked;
      len_r    <= q_data.length;
      text_r   <= q_data.data ^ q_data.key;
      last_r   <= q_data.last;
    end
  end

  assign out_valid           = valid_r;
  assign out_result_kind     = kind_r;
  assign out_fin_flag        = fin_r;
  assign out_frame_kind      = fkind_r;
  assign out_is_masked       = masked_r;
  assign out_payload_length  = len_r;
  assign out_text_byte       = text_r;
  assign out_last_of_payload = last_r;

endmodule
